>>> rtl/pgp_packet_header_parser_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packet header parser
// Concurrent check shorthands used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PGP_PACKET_HEADER_PARSER_DEFINES_SVH
`define PGP_PACKET_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PGP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PGP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/pgphp_pkg.sv
// ----------------------------------------------------------------------------
// pgphp_pkg
// Types and constants shared by the packet header parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgphp_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_HDR  = 3'd0,
      PH_LEN1 = 3'd1,
      PH_LEN2 = 3'd2,
      PH_LEN4 = 3'd3,
      PH_BODY = 3'd4
   } phase_type;

   // result event codes
   typedef enum logic [2:0] {
      EV_HDR_BYTE  = 3'd0,
      EV_HDR_DONE  = 3'd1,
      EV_BODY      = 3'd2,
      EV_MALFORMED = 3'd3,
      EV_PARTIAL   = 3'd4,
      EV_TRUNC     = 3'd5,
      EV_END       = 3'd6
   } event_type;

   localparam logic [7:0]  LEN_TWO_MIN  = 8'd192;   // first byte of two-byte form
   localparam logic [7:0]  LEN_PART_MIN = 8'd224;   // partial length codes start
   localparam logic [7:0]  LEN_FIVE     = 8'd255;   // four-byte form marker
   localparam logic [7:0]  HDR_MASK     = 8'hC0;    // bits that must be set
   localparam logic [7:0]  TAG_MASK     = 8'h3F;
   localparam logic [31:0] LEN_TWO_BIAS = 32'd192;
   localparam logic [2:0]  LEN4_BYTES   = 3'd4;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      event_type   event_res;
      logic [5:0]  packet_tag;
      logic [31:0] body_length;
      logic [7:0]  body_byte;
      logic        last_body;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/pgphp_in_stage.sv
// ----------------------------------------------------------------------------
// pgphp_in_stage
// Input register; holds one transaction until the parser consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgphp_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pgphp_pkg::req_type req_data,
   input  wire logic             take,
   output logic                  in_valid,
   output pgphp_pkg::req_type    in_data
);
   import pgphp_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/pgphp_core.sv
// ----------------------------------------------------------------------------
// pgphp_core
// Parser state and single-pass decode of one stream byte into one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgphp_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire pgphp_pkg::req_type in_data,
   output pgphp_pkg::rsp_type      rsp_next
);
   import pgphp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [5:0]  tag_ff, tag_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  len_left_ff, len_left_in;
   logic [31:0] body_left_ff, body_left_in;

   logic [7:0]  b;
   logic [31:0] acc_shift;
   logic [2:0]  len_left_dec;
   logic [31:0] body_left_dec;
   logic [31:0] two_len;
   logic        last;

   assign b             = in_data.stream_byte;
   assign acc_shift     = {acc_ff[23:0], b};
   assign len_left_dec  = (len_left_ff != 3'd0) ? len_left_ff - 3'd1 : len_left_ff;
   assign body_left_dec = (body_left_ff != 32'd0) ? body_left_ff - 32'd1 : body_left_ff;
   assign two_len       = {19'd0, acc_ff[4:0], b} + LEN_TWO_BIAS;
   assign last          = (body_left_dec == 32'd0);

   always_comb begin
      phase_in     = phase_ff;
      tag_in       = tag_ff;
      acc_in       = acc_ff;
      len_left_in  = len_left_ff;
      body_left_in = body_left_ff;

      rsp_next             = '0;
      rsp_next.event_res   = EV_HDR_BYTE;
      rsp_next.packet_tag  = tag_ff;

      if (in_data.end_mark) begin
         if (phase_ff == PH_HDR || phase_ff == PH_LEN1 && 1'b0) begin
            rsp_next.event_res  = EV_END;
            rsp_next.packet_tag = 6'd0;
         end else if (phase_ff == PH_LEN1 || phase_ff == PH_LEN2 ||
                      phase_ff == PH_LEN4 || phase_ff == PH_BODY) begin
            rsp_next.event_res  = EV_TRUNC;
         end else begin
            rsp_next.event_res  = EV_END;
            rsp_next.packet_tag = 6'd0;
         end
         phase_in     = PH_HDR;
         acc_in       = '0;
         len_left_in  = '0;
         body_left_in = '0;
      end else begin
         case (phase_ff)
            PH_LEN1: begin
               if (b < LEN_TWO_MIN) begin
                  rsp_next.event_res   = EV_HDR_DONE;
                  rsp_next.body_length = {24'd0, b};
                  acc_in       = '0;
                  len_left_in  = '0;
                  body_left_in = {24'd0, b};
                  phase_in     = (b != 8'd0) ? PH_BODY : PH_HDR;
               end else if (b < LEN_PART_MIN) begin
                  acc_in      = {27'd0, b[4:0]};
                  len_left_in = 3'd1;
                  phase_in    = PH_LEN2;
               end else if (b == LEN_FIVE) begin
                  acc_in      = '0;
                  len_left_in = LEN4_BYTES;
                  phase_in    = PH_LEN4;
               end else begin
                  rsp_next.event_res = EV_PARTIAL;
                  phase_in     = PH_HDR;
                  acc_in       = '0;
                  len_left_in  = '0;
                  body_left_in = '0;
               end
            end
            PH_LEN2: begin
               rsp_next.event_res   = EV_HDR_DONE;
               rsp_next.body_length = two_len;
               acc_in       = '0;
               len_left_in  = '0;
               body_left_in = two_len;
               phase_in     = PH_BODY;   // two-byte form is never zero
            end
            PH_LEN4: begin
               if (len_left_dec == 3'd0) begin
                  rsp_next.event_res   = EV_HDR_DONE;
                  rsp_next.body_length = acc_shift;
                  acc_in       = '0;
                  len_left_in  = '0;
                  body_left_in = acc_shift;
                  phase_in     = (acc_shift != 32'd0) ? PH_BODY : PH_HDR;
               end else begin
                  acc_in      = acc_shift;
                  len_left_in = len_left_dec;
               end
            end
            PH_BODY: begin
               rsp_next.event_res = EV_BODY;
               rsp_next.body_byte = b;
               rsp_next.last_body = last;
               if (last) begin
                  phase_in     = PH_HDR;
                  acc_in       = '0;
                  len_left_in  = '0;
                  body_left_in = '0;
               end else begin
                  body_left_in = body_left_dec;
               end
            end
            default: begin
               if ((b & HDR_MASK) != HDR_MASK) begin
                  rsp_next.event_res  = EV_MALFORMED;
                  rsp_next.packet_tag = b[5:0];
                  phase_in     = PH_HDR;
                  acc_in       = '0;
                  len_left_in  = '0;
                  body_left_in = '0;
               end else begin
                  tag_in              = (b & TAG_MASK) >> 0 == 8'd0 ? 6'd0 : b[5:0];
                  rsp_next.packet_tag = b[5:0];
                  phase_in            = PH_LEN1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR;
         tag_ff       <= '0;
         acc_ff       <= '0;
         len_left_ff  <= '0;
         body_left_ff <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         tag_ff       <= tag_in;
         acc_ff       <= acc_in;
         len_left_ff  <= len_left_in;
         body_left_ff <= body_left_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pgphp_out_stage.sv
// ----------------------------------------------------------------------------
// pgphp_out_stage
// Result register; holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgphp_out_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire pgphp_pkg::rsp_type rsp_next,
   output logic                    free,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output pgphp_pkg::rsp_type      rsp_data
);
   import pgphp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/pgp_packet_header_parser.sv
// ----------------------------------------------------------------------------
// pgp_packet_header_parser
// Byte-stream deframer for new-format packets: header, length, body.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake              Payload
//   req_     in   req_valid/req_ready    req_stream_byte, req_end_mark
//   rsp_     out  rsp_valid/rsp_ready    rsp_event_res, rsp_packet_tag,
//                                        rsp_body_length, rsp_body_byte,
//                                        rsp_last_body
//
// One result transaction per input transaction, one transaction per cycle
// sustained while the sink stays ready. A transaction passes the input
// register, then is decoded into the result register. The parser state
// updates in the same cycle the result register loads. Synchronous reset
// empties both registers and returns the parser to waiting for a header
// byte. A stalled sink holds the result register; the input register still
// takes one more transaction before req_ready drops.
//
`timescale 1ns / 1ps
`default_nettype none

`include "pgp_packet_header_parser_defines.svh"

module pgp_packet_header_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   // input byte stream
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_stream_byte,
   input  wire logic        req_end_mark,
   // result events
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_res,
   output logic [5:0]       rsp_packet_tag,
   output logic [31:0]      rsp_body_length,
   output logic [7:0]       rsp_body_byte,
   output logic             rsp_last_body
);
   import pgphp_pkg::*;

   req_type req_data;
   req_type in_data;
   rsp_type rsp_next;
   rsp_type rsp_data;
   logic    in_valid;
   logic    out_free;
   logic    step;

   assign req_data.stream_byte = req_stream_byte;
   assign req_data.end_mark    = req_end_mark;

   // a byte is decoded when one is held and the result register can load
   assign step = in_valid && out_free;

   pgphp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .take      (step),
      .in_valid  (in_valid),
      .in_data   (in_data)
   );

   pgphp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .in_data  (in_data),
      .rsp_next (rsp_next)
   );

   pgphp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .rsp_next  (rsp_next),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_event_res   = rsp_data.event_res;
   assign rsp_packet_tag  = rsp_data.packet_tag;
   assign rsp_body_length = rsp_data.body_length;
   assign rsp_body_byte   = rsp_data.body_byte;
   assign rsp_last_body   = rsp_data.last_body;

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   `PGP_ASSERT_IMP(a_last_only_body, clock, reset, rsp_valid && rsp_last_body, rsp_data.event_res == EV_BODY, "last_body outside a body byte")
   `PGP_ASSERT_IMP(a_len_only_done, clock, reset, rsp_valid && rsp_body_length != 32'd0, rsp_data.event_res == EV_HDR_DONE, "length outside header done")
   `PGP_ASSERT_IMP(a_full_stall, clock, reset, rsp_valid && !rsp_ready && in_valid, !req_ready, "input taken while both stages full")
   `PGP_ASSERT_NXT(a_step_loads, clock, reset, step, rsp_valid, "decoded byte produced no result")

endmodule

`default_nettype wire
